// ===== rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int SLOT_COUNT_DEF = 128;
    localparam int SLOT_W         = 7;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

// ===== rtl/bitmap_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// Slot allocator over a pool of SLOT_COUNT entries, one free bit per slot.
// ----------------------------------------------------------------------------
// Pulse start with an operation to allocate the lowest free slot or to free a
// named slot. A new item is taken in every cycle and busy is always low. The
// result shows on o_strobe, o_granted and o_slot_number once the item has
// passed the input register and the output register, and for one cycle only:
// the receiver cannot stall it. The rate of one item per cycle is set by the
// find-first-free search, a lowest-set-bit isolate and encode over the whole
// free map, done in the same cycle that updates the map, so each item sees the
// effect of the one before it. All slots are free after reset.
module bitmap_slot_allocator_core #(
    parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bsa_pkg::t_op               i_operation,
    input  logic [bsa_pkg::SLOT_W-1:0] i_release_slot,
    output logic                       o_strobe,
    output logic                       o_granted,
    output logic [bsa_pkg::SLOT_W-1:0] o_slot_number
);
    import bsa_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ENC_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    logic                  r_in_valid;
    t_op                   r_op;
    logic [SLOT_W-1:0]     r_slot;

    logic [SLOT_COUNT-1:0] r_free_map;
    logic [SLOT_COUNT-1:0] n_free_map;

    logic                  r_strobe;
    logic                  r_granted;
    logic [SLOT_W-1:0]     r_slot_number;
    logic                  n_granted;
    logic [SLOT_W-1:0]     n_slot_number;

    logic [SLOT_COUNT-1:0] lowest_free;
    logic [ENC_W-1:0]      lowest_idx;
    logic [ENC_W-1:0]      slot_ext;
    logic                  slot_in_range;

    assign busy = 1'b0;

    // register the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        r_op   <= i_operation;
        r_slot <= i_release_slot;
    end

    // isolate the lowest free bit, then encode it
    assign lowest_free = r_free_map & (~r_free_map + SLOT_COUNT'(1));

    always_comb begin
        lowest_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (lowest_free[i]) begin
                lowest_idx = lowest_idx | ENC_W'(i);
            end
        end
    end

    assign slot_ext      = ENC_W'(r_slot);
    assign slot_in_range = (int'(r_slot) < SLOT_COUNT);

    always_comb begin
        n_free_map    = r_free_map;
        n_granted     = 1'b0;
        n_slot_number = '0;
        if (r_in_valid) begin
            case (r_op)
                OP_ALLOC: begin
                    if (|r_free_map) begin
                        n_free_map    = r_free_map & ~lowest_free;
                        n_granted     = 1'b1;
                        n_slot_number = lowest_idx[SLOT_W-1:0];
                    end
                end
                OP_FREE: begin
                    // drop a release beyond the pool
                    if (slot_in_range) begin
                        n_free_map[slot_ext[IDX_W-1:0]] = 1'b1;
                        n_granted     = 1'b1;
                        n_slot_number = r_slot;
                    end
                end
                default: begin
                    n_free_map = r_free_map;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= '1;
            r_strobe   <= 1'b0;
        end else begin
            r_free_map <= n_free_map;
            r_strobe   <= r_in_valid;
        end
        r_granted     <= n_granted;
        r_slot_number <= n_slot_number;
    end

    assign o_strobe      = r_strobe;
    assign o_granted     = r_granted;
    assign o_slot_number = r_slot_number;

endmodule

// ===== rtl/bsa_checker.sv =====
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks for the bitmap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker #(
    parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input bsa_pkg::t_op               i_operation,
    input logic [bsa_pkg::SLOT_W-1:0] i_release_slot,
    input logic                       o_strobe,
    input logic                       o_granted,
    input logic [bsa_pkg::SLOT_W-1:0] o_slot_number
);
    import bsa_pkg::*;

    // every taken item yields a result on o_strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("missing result for taken item");

    // no result without an item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_strobe)
        else $error("result without item");

    // a refused item reports slot zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_granted) |-> (o_slot_number == '0))
        else $error("refused item with nonzero slot");

    // an in-range free is always granted and echoes the slot
    a_free_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_FREE) &&
         (int'(i_release_slot) < SLOT_COUNT))
        |-> ##2 (o_granted && (o_slot_number == $past(i_release_slot, 2))))
        else $error("free not granted or slot not echoed");

endmodule

bind bitmap_slot_allocator_core bsa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_bsa_checker (.*);
